// File: rtl/bucr_pkg.sv
// Shared constants, result type and weight test of the bone palette compaction block.
`timescale 1ns / 1ps
`default_nettype none

package bucr_pkg;

  localparam int unsigned MAX_BONES_DEF = 256;
  localparam int unsigned LANES         = 4;
  localparam int unsigned CMD_DEPTH     = 4;
  localparam int unsigned RES_DEPTH     = 2;

  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned LOCAL_W    = 8;
  localparam int unsigned TOTAL_W    = 9;
  localparam int unsigned GLOBAL_W   = 8;
  localparam int unsigned BONE_CNT_W = 9;

  localparam logic [BONE_CNT_W-1:0] BONE_COUNT_RESET = 9'd256;

  // IEEE single bits of 1e-6 and of positive infinity.
  localparam logic [WORD_W-1:0] WEIGHT_MIN_BITS = 32'h3586_37BD;
  localparam logic [WORD_W-1:0] POS_INF_BITS    = 32'h7F80_0000;

  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_MARK    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPACT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMAP   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ    = 3'd4;

  typedef struct packed {
    logic [LANES-1:0][LOCAL_W-1:0] local_idx;
    logic [TOTAL_W-1:0]            used_total;
    logic [GLOBAL_W-1:0]           palette_global;
    logic                          status;
  } res_t;

  // Positive finite values above the threshold and +infinity pass; the sign bit,
  // both zeros and every NaN pattern fail, which unsigned ordering gives directly.
  function automatic logic weight_ok(input logic [WORD_W-1:0] bits);
    return (bits > WEIGHT_MIN_BITS) && (bits <= POS_INF_BITS);
  endfunction

endpackage

`default_nettype wire

// File: rtl/bucr_fifo.sv
// Small first-in first-out queue used for the command and result paths.
`timescale 1ns / 1ps
`default_nettype none

module bucr_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t rdata_o,
  output logic  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bucr_front.sv
// Front end: classifies each incoming transaction and queues it for the back end.
`timescale 1ns / 1ps
`default_nettype none

module bucr_front #(
  parameter int unsigned MAX_BONES = bucr_pkg::MAX_BONES_DEF,
  parameter type cmd_t = logic
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             push_i,
  output logic                                             full_o,
  input  logic [bucr_pkg::OPCODE_W-1:0]                    opcode_i,
  input  logic [bucr_pkg::LANES-1:0][bucr_pkg::WORD_W-1:0] bone_index_i,
  input  logic [bucr_pkg::LANES-1:0][bucr_pkg::WORD_W-1:0] weight_i,
  input  logic [bucr_pkg::POS_W-1:0]                       palette_position_i,
  input  logic [$clog2(MAX_BONES+1)-1:0]                   eff_count_i,
  output cmd_t                                             cmd_o,
  output logic                                             cmd_empty_o,
  input  logic                                             cmd_pop_i
);

  import bucr_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BONES);

  cmd_t cmd_in;

  always_comb begin
    logic wok;
    cmd_in          = '0;
    cmd_in.opcode   = opcode_i;
    cmd_in.position = palette_position_i;
    for (int l = 0; l < LANES; l++) begin
      wok                = weight_ok(weight_i[l]);
      cmd_in.idx[l]      = IW'(bone_index_i[l]);
      // Marking honours the configured skeleton size, remapping only the table size.
      cmd_in.mark_en[l]  = wok && (bone_index_i[l] < WORD_W'(eff_count_i));
      cmd_in.remap_en[l] = wok && (bone_index_i[l] < WORD_W'(MAX_BONES));
    end
  end

  bucr_fifo #(
    .DEPTH  (CMD_DEPTH),
    .item_t (cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

`default_nettype wire

// File: rtl/bucr_back.sv
// Back end: holds the bone tables and carries out queued commands one at a time.
`timescale 1ns / 1ps
`default_nettype none

module bucr_back #(
  parameter int unsigned MAX_BONES = bucr_pkg::MAX_BONES_DEF,
  parameter type cmd_t = logic
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cmd_t                           cmd_i,
  input  logic                           cmd_empty_i,
  output logic                           cmd_pop_o,
  input  logic [$clog2(MAX_BONES+1)-1:0] eff_count_i,
  output bucr_pkg::res_t                 res_o,
  output logic                           res_push_o,
  input  logic                           res_full_i
);

  import bucr_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_BONES);
  localparam int unsigned CW  = $clog2(MAX_BONES + 1);
  localparam int unsigned LW  = $clog2(LANES);
  localparam int unsigned LNW = $clog2(LANES + 1);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_COMPACT = 2'd1;
  localparam logic [1:0] ST_REMAP   = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [MAX_BONES-1:0]          flags_q, flags_d;
  logic [MAX_BONES-1:0]          valid_q, valid_d;
  logic [TOTAL_W-1:0]            used_count_q, used_count_d;
  cmd_t                          cur_q, cur_d;
  logic [LNW-1:0]                lane_q, lane_d;
  logic [CW-1:0]                 g_q, g_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [LANES-1:0][LOCAL_W-1:0] loc_q, loc_d;

  logic [LOCAL_W-1:0]  g2l_mem_q [MAX_BONES];
  logic [GLOBAL_W-1:0] pal_mem_q [MAX_BONES];
  logic [LOCAL_W-1:0]  g2l_rd_q;
  logic [GLOBAL_W-1:0] pal_rd_q;

  logic                g2l_we, g2l_re, pal_we, pal_re;
  logic [IW-1:0]       g2l_waddr, g2l_raddr, pal_waddr, pal_raddr;
  logic [LOCAL_W-1:0]  g2l_wdata;
  logic [GLOBAL_W-1:0] pal_wdata;

  always_comb begin
    logic [CW-1:0]  cnt_next;
    logic [CW-1:0]  g_next;
    logic [LNW-1:0] prev_lane;
    state_d      = state_q;
    flags_d      = flags_q;
    valid_d      = valid_q;
    used_count_d = used_count_q;
    cur_d        = cur_q;
    lane_d       = lane_q;
    g_d          = g_q;
    cnt_d        = cnt_q;
    loc_d        = loc_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    res_o        = '0;
    g2l_we       = 1'b0;
    g2l_re       = 1'b0;
    pal_we       = 1'b0;
    pal_re       = 1'b0;
    g2l_waddr    = g_q[IW-1:0];
    g2l_wdata    = LOCAL_W'(cnt_q);
    pal_waddr    = cnt_q[IW-1:0];
    pal_wdata    = GLOBAL_W'(g_q);
    g2l_raddr    = cur_q.idx[0];
    pal_raddr    = IW'(cmd_i.position);
    cnt_next     = cnt_q;
    g_next       = g_q + CW'(1);
    prev_lane    = lane_q - LNW'(1);

    unique case (state_q)
      ST_IDLE: begin
        // A command starts only when the result queue has room for its answer.
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.opcode)
            OP_CLEAR: begin
              flags_d    = '0;
              res_push_o = 1'b1;
            end
            OP_MARK: begin
              for (int l = 0; l < LANES; l++) begin
                if (cmd_i.mark_en[l]) begin
                  flags_d[cmd_i.idx[l]] = 1'b1;
                end
              end
              res_push_o = 1'b1;
            end
            OP_COMPACT: begin
              valid_d = '0;
              g_d     = '0;
              cnt_d   = '0;
              if (eff_count_i == '0) begin
                used_count_d = '0;
                res_push_o   = 1'b1;
              end else begin
                state_d = ST_COMPACT;
              end
            end
            OP_REMAP: begin
              cur_d     = cmd_i;
              g2l_re    = 1'b1;
              g2l_raddr = cmd_i.idx[0];
              lane_d    = LNW'(1);
              state_d   = ST_REMAP;
            end
            OP_READ: begin
              if ((WORD_W'(cmd_i.position) < WORD_W'(used_count_q)) &&
                  (WORD_W'(cmd_i.position) < WORD_W'(MAX_BONES))) begin
                pal_re  = 1'b1;
                state_d = ST_READ;
              end else begin
                res_o.status = 1'b1;
                res_push_o   = 1'b1;
              end
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      ST_COMPACT: begin
        if (flags_q[g_q[IW-1:0]]) begin
          g2l_we                = 1'b1;
          pal_we                = 1'b1;
          valid_d[g_q[IW-1:0]]  = 1'b1;
          cnt_next              = cnt_q + CW'(1);
        end
        g_d   = g_next;
        cnt_d = cnt_next;
        if (g_next == eff_count_i) begin
          used_count_d = TOTAL_W'(cnt_next);
          res_push_o   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_REMAP: begin
        // The table word for the previous lane arrives while the next lane is looked up.
        loc_d[prev_lane[LW-1:0]] =
          (cur_q.remap_en[prev_lane[LW-1:0]] && valid_q[cur_q.idx[prev_lane[LW-1:0]]]) ?
          g2l_rd_q : '0;
        if (lane_q < LNW'(LANES)) begin
          g2l_re    = 1'b1;
          g2l_raddr = cur_q.idx[lane_q[LW-1:0]];
          lane_d    = lane_q + LNW'(1);
        end else begin
          res_o.local_idx = loc_d;
          res_push_o      = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_READ: begin
        res_o.palette_global = pal_rd_q;
        res_push_o           = 1'b1;
        state_d              = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_o.used_total = used_count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      flags_q      <= '0;
      valid_q      <= '0;
      used_count_q <= '0;
    end else begin
      state_q      <= state_d;
      flags_q      <= flags_d;
      valid_q      <= valid_d;
      used_count_q <= used_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    lane_q <= lane_d;
    g_q    <= g_d;
    cnt_q  <= cnt_d;
    loc_q  <= loc_d;
  end

  always_ff @(posedge clk_i) begin
    if (g2l_we) begin
      g2l_mem_q[g2l_waddr] <= g2l_wdata;
    end
    if (g2l_re) begin
      g2l_rd_q <= g2l_mem_q[g2l_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem_q[pal_waddr] <= pal_wdata;
    end
    if (pal_re) begin
      pal_rd_q <= pal_mem_q[pal_raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bone_usage_compact_remap.sv
// Top level of the bone palette compaction and blend-index remap block.
//
// Transactions enter a four-deep command queue and are carried out in order by the back
// end, whose answers wait in a two-deep result queue. Once started, clear, mark and
// unknown opcodes answer in the cycle they start in, a palette read answers from one
// registered palette memory read, or at once when the slot lies at or beyond the used
// total, a remap looks up its four lanes in turn, since they share the one read port of
// the mapping memory, and then collects the last lane's word, and a compact walks the
// used flags in ascending order over the effective skeleton size, min(bone_count,
// MAX_BONES). Mark transactions run at one per cycle while the result queue has room.
// bone_count may be written only while no transaction is outstanding.
`timescale 1ns / 1ps
`default_nettype none

module bone_usage_compact_remap #(
  parameter int unsigned MAX_BONES = bucr_pkg::MAX_BONES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bucr_pkg::BONE_CNT_W-1:0]    cfg_wdata_i,
  input  logic                               push,
  output logic                               full,
  input  logic [bucr_pkg::OPCODE_W-1:0]      opcode_i,
  input  logic [bucr_pkg::WORD_W-1:0]        bone_index_a_i,
  input  logic [bucr_pkg::WORD_W-1:0]        bone_index_b_i,
  input  logic [bucr_pkg::WORD_W-1:0]        bone_index_c_i,
  input  logic [bucr_pkg::WORD_W-1:0]        bone_index_d_i,
  input  logic [bucr_pkg::WORD_W-1:0]        weight_a_i,
  input  logic [bucr_pkg::WORD_W-1:0]        weight_b_i,
  input  logic [bucr_pkg::WORD_W-1:0]        weight_c_i,
  input  logic [bucr_pkg::WORD_W-1:0]        weight_d_i,
  input  logic [bucr_pkg::POS_W-1:0]         palette_position_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [bucr_pkg::LOCAL_W-1:0]       local_a_o,
  output logic [bucr_pkg::LOCAL_W-1:0]       local_b_o,
  output logic [bucr_pkg::LOCAL_W-1:0]       local_c_o,
  output logic [bucr_pkg::LOCAL_W-1:0]       local_d_o,
  output logic [bucr_pkg::TOTAL_W-1:0]       used_total_o,
  output logic [bucr_pkg::GLOBAL_W-1:0]      palette_global_o,
  output logic                               status_o
);

  import bucr_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BONES);
  localparam int unsigned CW = $clog2(MAX_BONES + 1);

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [LANES-1:0][IW-1:0] idx;
    logic [LANES-1:0]         mark_en;
    logic [LANES-1:0]         remap_en;
    logic [POS_W-1:0]         position;
  } cmd_t;

  logic [BONE_CNT_W-1:0]      bone_count_q;
  logic [CW-1:0]              eff_count;
  logic [LANES-1:0][WORD_W-1:0] bone_index;
  logic [LANES-1:0][WORD_W-1:0] weight;
  cmd_t                       cmd;
  logic                       cmd_empty, cmd_pop;
  res_t                       res_in, res_out;
  logic                       res_push, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bone_count_q <= BONE_COUNT_RESET;
    end else if (cfg_we_i) begin
      bone_count_q <= cfg_wdata_i;
    end
  end

  assign eff_count = (WORD_W'(bone_count_q) < WORD_W'(MAX_BONES)) ?
                     CW'(bone_count_q) : CW'(MAX_BONES);

  assign bone_index = {bone_index_d_i, bone_index_c_i, bone_index_b_i, bone_index_a_i};
  assign weight     = {weight_d_i, weight_c_i, weight_b_i, weight_a_i};

  bucr_front #(
    .MAX_BONES (MAX_BONES),
    .cmd_t     (cmd_t)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push),
    .full_o             (full),
    .opcode_i           (opcode_i),
    .bone_index_i       (bone_index),
    .weight_i           (weight),
    .palette_position_i (palette_position_i),
    .eff_count_i        (eff_count),
    .cmd_o              (cmd),
    .cmd_empty_o        (cmd_empty),
    .cmd_pop_i          (cmd_pop)
  );

  bucr_back #(
    .MAX_BONES (MAX_BONES),
    .cmd_t     (cmd_t)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .eff_count_i (eff_count),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  bucr_fifo #(
    .DEPTH  (RES_DEPTH),
    .item_t (res_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign local_a_o        = res_out.local_idx[0];
  assign local_b_o        = res_out.local_idx[1];
  assign local_c_o        = res_out.local_idx[2];
  assign local_d_o        = res_out.local_idx[3];
  assign used_total_o     = res_out.used_total;
  assign palette_global_o = res_out.palette_global;
  assign status_o         = res_out.status;

  // The back end must never produce an answer with nowhere to put it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !(pop && !empty)) |=> !empty)
    else $error("a produced result did not appear on the result side");

  // A failed palette read reports no global index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> (palette_global_o == '0))
    else $error("palette read error carries a non-zero global index");

endmodule

`default_nettype wire

// File: tb/sv/bone_usage_compact_remap_tb.sv
// Self-checking testbench of the bone palette compaction and blend-index remap block.
`timescale 1ns / 1ps

module bone_usage_compact_remap_tb;
  import bucr_pkg::*;

  localparam int unsigned BONES        = MAX_BONES_DEF;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT  = 900_000;

  // Opcodes the block does not define.
  localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic [WORD_W-1:0] W_ONE        = 32'h3F80_0000;
  localparam logic [WORD_W-1:0] W_ZERO       = 32'h0000_0000;
  localparam logic [WORD_W-1:0] W_NEG_ZERO   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] W_NEG_ONE    = 32'hBF80_0000;
  localparam logic [WORD_W-1:0] W_MAX_FINITE = 32'h7F7F_FFFF;
  localparam logic [WORD_W-1:0] W_ALL_ONES   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [OPCODE_W-1:0]           opcode;
    logic [LANES-1:0][WORD_W-1:0]  bone_index;
    logic [LANES-1:0][WORD_W-1:0]  weight;
    logic [POS_W-1:0]              pos;
  } bone_cmd_t;

  typedef struct packed {
    logic [LANES-1:0][LOCAL_W-1:0] lane_local;
    logic [TOTAL_W-1:0]            used_total;
    logic [GLOBAL_W-1:0]           palette_global;
    logic                          status;
  } remap_res_t;

  typedef struct packed {
    bone_cmd_t  cmd;
    logic       typed;
    remap_res_t res;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [BONE_CNT_W-1:0]   cfg_wdata_i = '0;
  logic                    push = 1'b0;
  logic                    full;
  logic [OPCODE_W-1:0]     opcode_i = '0;
  logic [WORD_W-1:0]       bone_index_a_i = '0;
  logic [WORD_W-1:0]       bone_index_b_i = '0;
  logic [WORD_W-1:0]       bone_index_c_i = '0;
  logic [WORD_W-1:0]       bone_index_d_i = '0;
  logic [WORD_W-1:0]       weight_a_i = '0;
  logic [WORD_W-1:0]       weight_b_i = '0;
  logic [WORD_W-1:0]       weight_c_i = '0;
  logic [WORD_W-1:0]       weight_d_i = '0;
  logic [POS_W-1:0]        palette_position_i = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [LOCAL_W-1:0]      local_a_o;
  logic [LOCAL_W-1:0]      local_b_o;
  logic [LOCAL_W-1:0]      local_c_o;
  logic [LOCAL_W-1:0]      local_d_o;
  logic [TOTAL_W-1:0]      used_total_o;
  logic [GLOBAL_W-1:0]     palette_global_o;
  logic                    status_o;

  bone_usage_compact_remap i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .push               (push),
    .full               (full),
    .opcode_i           (opcode_i),
    .bone_index_a_i     (bone_index_a_i),
    .bone_index_b_i     (bone_index_b_i),
    .bone_index_c_i     (bone_index_c_i),
    .bone_index_d_i     (bone_index_d_i),
    .weight_a_i         (weight_a_i),
    .weight_b_i         (weight_b_i),
    .weight_c_i         (weight_c_i),
    .weight_d_i         (weight_d_i),
    .palette_position_i (palette_position_i),
    .empty              (empty),
    .pop                (pop),
    .local_a_o          (local_a_o),
    .local_b_o          (local_b_o),
    .local_c_o          (local_c_o),
    .local_d_o          (local_d_o),
    .used_total_o       (used_total_o),
    .palette_global_o   (palette_global_o),
    .status_o           (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: the usage flags, the mapping of the last compact and the palette.
  logic                  used_flags [BONES];
  logic                  map_valid [BONES];
  logic [TOTAL_W-1:0]    global_to_local [BONES];
  logic [GLOBAL_W-1:0]   palette [BONES];
  logic [TOTAL_W-1:0]    used_count;
  logic [BONE_CNT_W-1:0] bone_count;

  remap_res_t  awaited_results [$];
  stim_row_t   stim_table [$];
  int unsigned sent_items = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  string       lane_name [LANES] = '{"local_a", "local_b", "local_c", "local_d"};
  logic [BONE_CNT_W-1:0] cfg_plan [8] = '{9'd511, 9'd1, 9'd0, 9'd256, 9'd2, 9'd257,
                                          9'd255, 9'd64};

  function automatic int unsigned live_bones();
    return (bone_count > BONES) ? BONES : int'(bone_count);
  endfunction

  // Above 1e-6 and at most +infinity; the sign bit rules out negatives and negative NaNs, the bound the other NaNs.
  function automatic bit weight_passes(input logic [WORD_W-1:0] bits);
    return !bits[31] && (bits[30:0] > WEIGHT_MIN_BITS[30:0]) &&
           (bits[30:0] <= POS_INF_BITS[30:0]);
  endfunction

  function automatic remap_res_t apply_bone_op(input bone_cmd_t c);
    remap_res_t  r;
    int unsigned n;
    int unsigned cnt;
    int unsigned g;
    logic [WORD_W-1:0] idx;
    r = '0;
    n = live_bones();
    case (c.opcode)
      OP_CLEAR: begin
        for (g = 0; g < BONES; g++) used_flags[g] = 1'b0;
      end
      OP_MARK: begin
        for (int lane = 0; lane < LANES; lane++) begin
          idx = c.bone_index[lane];
          if (weight_passes(c.weight[lane]) && idx < n) used_flags[idx[7:0]] = 1'b1;
        end
      end
      OP_COMPACT: begin
        cnt = 0;
        for (g = 0; g < BONES; g++) map_valid[g] = 1'b0;
        for (g = 0; g < n; g++) begin
          if (used_flags[g]) begin
            global_to_local[g] = cnt[TOTAL_W-1:0];
            map_valid[g] = 1'b1;
            palette[cnt] = g[GLOBAL_W-1:0];
            cnt++;
          end
        end
        used_count = cnt[TOTAL_W-1:0];
      end
      OP_REMAP: begin
        for (int lane = 0; lane < LANES; lane++) begin
          idx = c.bone_index[lane];
          if (weight_passes(c.weight[lane]) && idx < BONES && map_valid[idx[7:0]])
            r.lane_local[lane] = global_to_local[idx[7:0]][LOCAL_W-1:0];
        end
      end
      OP_READ: begin
        if (c.pos < used_count) r.palette_global = palette[c.pos];
        else r.status = 1'b1;
      end
      default: begin
      end
    endcase
    r.used_total = used_count;
    return r;
  endfunction

  function automatic bone_cmd_t mk_cmd(input logic [OPCODE_W-1:0] op,
                                       input logic [WORD_W-1:0] i0, i1, i2, i3,
                                       input logic [WORD_W-1:0] w0, w1, w2, w3,
                                       input logic [POS_W-1:0] pos);
    bone_cmd_t c;
    c.opcode = op;
    c.bone_index = {i3, i2, i1, i0};
    c.weight = {w3, w2, w1, w0};
    c.pos = pos;
    return c;
  endfunction

  function automatic remap_res_t mk_res(input logic [TOTAL_W-1:0] total,
                                        input logic [GLOBAL_W-1:0] glob,
                                        input logic status);
    remap_res_t r;
    r = '0;
    r.used_total = total;
    r.palette_global = glob;
    r.status = status;
    return r;
  endfunction

  task automatic add_row(input bone_cmd_t c, input bit typed, input remap_res_t r);
    stim_row_t row;
    row.cmd = c;
    row.typed = typed;
    row.res = r;
    stim_table.insert(stim_table.size(), row);
  endtask

  function automatic logic [WORD_W-1:0] pick_index();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 511);
      2:       v = W_ALL_ONES - $urandom_range(0, 3);
      default: v = $urandom_range(0, live_bones());
    endcase
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] pick_weight();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 1) ? W_ZERO : W_NEG_ZERO;
      2:       v = WEIGHT_MIN_BITS - 1 + $urandom_range(0, 2);
      3:       v = POS_INF_BITS + $urandom_range(0, 1);
      4:       v = $urandom | W_NEG_ZERO;
      default: v = $urandom_range(32'h3A00_0000, W_ONE);
    endcase
    return v;
  endfunction

  function automatic bone_cmd_t rand_cmd(input logic [OPCODE_W-1:0] op);
    bone_cmd_t   c;
    int unsigned top;
    c.opcode = op;
    for (int lane = 0; lane < LANES; lane++) begin
      c.bone_index[lane] = pick_index();
      c.weight[lane] = pick_weight();
    end
    top = (used_count + 1 > 255) ? 255 : used_count + 1;
    c.pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 255)) :
                                          POS_W'($urandom_range(0, top));
    return c;
  endfunction

  // Now and then an opcode of any kind, the undefined ones included, breaks the sequence.
  function automatic logic [OPCODE_W-1:0] noisy_op(input logic [OPCODE_W-1:0] op);
    return ($urandom_range(0, 9) == 0) ? OPCODE_W'($urandom_range(0, 7)) : op;
  endfunction

  task automatic wait_all_results();
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send(input bone_cmd_t c, input bit typed, input remap_res_t typed_res);
    remap_res_t want;
    if (gaps_on && $urandom_range(0, 99) < 7) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push               <= 1'b1;
    opcode_i           <= c.opcode;
    bone_index_a_i     <= c.bone_index[0];
    bone_index_b_i     <= c.bone_index[1];
    bone_index_c_i     <= c.bone_index[2];
    bone_index_d_i     <= c.bone_index[3];
    weight_a_i         <= c.weight[0];
    weight_b_i         <= c.weight[1];
    weight_c_i         <= c.weight[2];
    weight_d_i         <= c.weight[3];
    palette_position_i <= c.pos;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    want = apply_bone_op(c);
    awaited_results.insert(awaited_results.size(), typed ? typed_res : want);
    sent_items++;
  endtask

  task automatic send_random(input logic [OPCODE_W-1:0] op);
    send(rand_cmd(op), 1'b0, '0);
  endtask

  // The skeleton size may only change with no transaction outstanding.
  task automatic write_bone_count(input logic [BONE_CNT_W-1:0] v);
    push <= 1'b0;
    wait_all_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bone_count = v;
  endtask

  // Usually a clear, then a run of marks, a compact, then remaps and palette reads.
  task automatic run_usage_phase(input bit pause_mid);
    int unsigned marks;
    int unsigned queries;
    if ($urandom_range(0, 4) != 0) send_random(OP_CLEAR);
    marks = $urandom_range(2, 12);
    for (int k = 0; k < marks; k++) send_random(noisy_op(OP_MARK));
    if (pause_mid) begin
      push <= 1'b0;
      wait_all_results();
    end
    send_random(OP_COMPACT);
    queries = $urandom_range(6, 16);
    for (int k = 0; k < queries; k++)
      send_random(noisy_op($urandom_range(0, 1) ? OP_REMAP : OP_READ));
  endtask

  // Every bone in use, so that the palette and the total reach their top values.
  task automatic run_full_palette_phase();
    bone_cmd_t c;
    send_random(OP_CLEAR);
    for (int k = 0; k < BONES / LANES; k++) begin
      c = rand_cmd(OP_MARK);
      for (int lane = 0; lane < LANES; lane++) begin
        c.bone_index[lane] = LANES * k + lane;
        c.weight[lane] = $urandom_range(32'h3A00_0000, W_MAX_FINITE);
      end
      send(c, 1'b0, '0);
    end
    send_random(OP_COMPACT);
    send(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 8'd255), 1'b0, '0);
    for (int k = 0; k < 12; k++) send_random($urandom_range(0, 1) ? OP_REMAP : OP_READ);
  endtask

  task automatic report(input string field, input logic [31:0] want_v,
                        input logic [31:0] got_v);
    $error("%s: expected %0h, actual %0h", field, want_v, got_v);
    error_count++;
  endtask

  task automatic check_result();
    remap_res_t want;
    remap_res_t got;
    got.lane_local     = {local_d_o, local_c_o, local_b_o, local_a_o};
    got.used_total     = used_total_o;
    got.palette_global = palette_global_o;
    got.status         = status_o;
    if (awaited_results.size() == 0) begin
      $error("result transaction with none outstanding");
      error_count++;
    end else begin
      want = awaited_results.pop_front();
      for (int lane = 0; lane < LANES; lane++)
        if (got.lane_local[lane] !== want.lane_local[lane])
          report(lane_name[lane], want.lane_local[lane], got.lane_local[lane]);
      if (got.used_total !== want.used_total)
        report("used_total", want.used_total, got.used_total);
      if (got.palette_global !== want.palette_global)
        report("palette_global", want.palette_global, got.palette_global);
      if (got.status !== want.status)
        report("status", want.status, got.status);
    end
  endtask

  // Result side: outputs are sampled as they stood before the edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_result();
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= !(stall_on && $urandom_range(0, 99) < 7);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned stop_at;
    for (int g = 0; g < BONES; g++) begin
      used_flags[g] = 1'b0;
      map_valid[g] = 1'b0;
      global_to_local[g] = '0;
      palette[g] = '0;
    end
    used_count = '0;
    bone_count = BONE_COUNT_RESET;

    // Reset state first, then marks that probe every weight and index boundary.
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 8'd0), 1'b1, mk_res(0, 0, 1'b1));
    add_row(mk_cmd(OP_REMAP, 0, 1, 2, 3, W_ONE, W_ONE, W_ONE, W_ONE, 0), 1'b1, mk_res(0, 0, 0));
    add_row(mk_cmd(OP_SPARE_5, 3, 3, 3, 3, W_ONE, W_ONE, W_ONE, W_ONE, 0), 1'b1,
            mk_res(0, 0, 0));
    add_row(mk_cmd(OP_SPARE_6, 3, 3, 3, 3, W_ONE, W_ONE, W_ONE, W_ONE, 8'd255), 1'b1,
            mk_res(0, 0, 0));
    add_row(mk_cmd(OP_SPARE_7, W_ALL_ONES, 0, 0, 0, W_ALL_ONES, 0, 0, 0, 8'd1), 1'b1,
            mk_res(0, 0, 0));
    add_row(mk_cmd(OP_MARK, 0, 255, 256, W_ALL_ONES, W_ONE, W_ONE, W_ONE, W_ONE, 0), 1'b1,
            mk_res(0, 0, 0));
    add_row(mk_cmd(OP_MARK, 3, 4, 5, 6, WEIGHT_MIN_BITS, WEIGHT_MIN_BITS + 1, POS_INF_BITS,
                   POS_INF_BITS + 1, 0), 1'b1, mk_res(0, 0, 0));
    add_row(mk_cmd(OP_MARK, 7, 8, 9, 10, W_NEG_ZERO, W_ZERO, W_NEG_ONE, W_ALL_ONES, 0), 1'b1,
            mk_res(0, 0, 0));
    add_row(mk_cmd(OP_COMPACT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(4, 0, 0));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 8'd0), 1'b0, '0);
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 8'd3), 1'b0, '0);
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 8'd4), 1'b1, mk_res(4, 0, 1'b1));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 8'd255), 1'b1, mk_res(4, 0, 1'b1));
    add_row(mk_cmd(OP_REMAP, 0, 4, 5, 255, W_ONE, W_ONE, W_ONE, W_ONE, 0), 1'b0, '0);
    add_row(mk_cmd(OP_REMAP, 255, 256, W_ALL_ONES, 4, W_ONE, W_ONE, W_ONE, W_ZERO, 0), 1'b0,
            '0);
    add_row(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(4, 0, 0));
    // A clear leaves the mapping of the last compact in place.
    add_row(mk_cmd(OP_REMAP, 4, 5, 255, 0, W_ONE, W_ONE, POS_INF_BITS, W_ONE, 0), 1'b0, '0);
    add_row(mk_cmd(OP_COMPACT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0));
    add_row(mk_cmd(OP_REMAP, 0, 4, 5, 255, W_ONE, W_ONE, W_ONE, W_ONE, 0), 1'b1,
            mk_res(0, 0, 0));
    add_row(mk_cmd(OP_MARK, 1, 2, 3, 200, W_MAX_FINITE, W_ONE, W_ONE, W_ONE, 0), 1'b1,
            mk_res(0, 0, 0));
    add_row(mk_cmd(OP_MARK, 0, 0, 1, 1, W_ONE, W_ONE, W_ONE, W_ONE, 0), 1'b1,
            mk_res(0, 0, 0));
    add_row(mk_cmd(OP_COMPACT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 8'd4), 1'b0, '0);
    add_row(mk_cmd(OP_REMAP, 200, 3, 2, 1, W_ONE, W_ONE, W_ONE, W_ONE, 0), 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) send(stim_table[i].cmd, stim_table[i].typed, stim_table[i].res);

    stop_at = sent_items + RANDOM_ITEMS;
    phase = 0;
    while (sent_items < stop_at) begin
      write_bone_count((phase < 8) ? cfg_plan[phase] : BONE_CNT_W'($urandom_range(0, 511)));
      // Two phases run with neither side idling.
      gaps_on  = (phase != 1) && (phase != 2);
      stall_on = gaps_on;
      if (phase == 3) hold_req = 1'b1;
      if (phase == 0) begin
        run_full_palette_phase();
      end else begin
        run_usage_phase(phase == 4);
        run_usage_phase(1'b0);
      end
      phase++;
    end

    push <= 1'b0;
    wait_all_results();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bucr_pkg.sv
rtl/bucr_fifo.sv
rtl/bucr_front.sv
rtl/bucr_back.sv
rtl/bone_usage_compact_remap.sv
tb/sv/bone_usage_compact_remap_tb.sv
